/* hdl/slir_pkg.sv */
// Shared types and codes for the sorted list insert/remove block.
package slir_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned GRP_SIZE = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    push;
    logic                    remove;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        pos;
  } bcast_t;

endpackage

/* hdl/sorted_list_insert_remove.sv */
// Top level of the sorted list: cell chain, count, read tree and output register.
//
// Keeps up to CAPACITY signed 32-bit keys in ascending order in a row of cells.
// Input channel in_*: in_tuser carries the command (push, remove, read), in_tdata
// the key and the position. Output channel out_*: one result per command, with
// the status in out_tuser and the read key and entry count in out_tdata.
// A push inserts after all equal keys; every cell compares and shifts in the
// same cycle, so the whole list updates at once. A remove closes the gap the
// same way. A read selects the addressed cell through a two-level OR tree with
// a register between the levels: the result passes the group registers and
// then the output register before it is presented.
// One command enters per cycle while results drain.
// When the receiver stalls, the result holds in the output register; one more
// command is taken into the middle stage, then in_tready drops until it frees.
// Reset empties the list (count zero) and drops pending results; the key cells
// are not cleared, as only positions below the count are ever read.
module sorted_list_insert_remove import slir_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key_value[31:0], position[39:32]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], entry_count[38:32], zero[39]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned GROUPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  cmd_t                    in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic [POS_W-1:0]        in_pos;

  logic                    accept;
  logic                    full;
  logic                    pos_ok;
  logic                    rd_ok;
  bcast_t                  bc;

  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;

  logic signed [KEY_W-1:0] keys   [CAPACITY];
  logic                    shifts [CAPACITY];

  logic                    pend_r;
  logic                    pend_nxt;
  status_t                 st_r;
  status_t                 st_nxt;
  logic [CNT_W-1:0]        cnt1_r;
  logic [KEY_W-1:0]        grp_r   [GROUPS];
  logic [KEY_W-1:0]        grp_nxt [GROUPS];
  logic [KEY_W-1:0]        rd_final;

  logic                    out_free;
  logic                    load;
  logic                    out_valid_r;
  status_t                 out_st_r;
  logic [KEY_W-1:0]        out_rd_r;
  logic [OUT_CNT_W-1:0]    out_cnt_r;

  assign in_cmd = cmd_t'(in_tuser);
  assign in_key = in_tdata[KEY_W-1:0];
  assign in_pos = in_tdata[KEY_W+POS_W-1:KEY_W];

  assign out_free  = !out_valid_r || out_tready;
  assign load      = pend_r && out_free;
  assign in_tready = !pend_r || out_free;
  assign accept    = in_tvalid && in_tready;

  assign full   = cnt_r == CNT_W'(CAPACITY);
  assign pos_ok = CMP_W'(in_pos) < CMP_W'(cnt_r);
  assign rd_ok  = (in_cmd == CMD_READ) && pos_ok;

  assign bc.push   = accept && (in_cmd == CMD_PUSH) && !full;
  assign bc.remove = accept && (in_cmd == CMD_REMOVE) && pos_ok;
  assign bc.key    = in_key;
  assign bc.pos    = in_pos;

  always_comb begin
    cnt_nxt = cnt_r;
    if (bc.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (bc.remove) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    st_nxt = ST_DONE;
    case (in_cmd)
      CMD_PUSH:   st_nxt = full ? ST_FULL : ST_DONE;
      CMD_REMOVE: st_nxt = pos_ok ? ST_DONE : ST_RANGE;
      CMD_READ:   st_nxt = pos_ok ? ST_DONE : ST_RANGE;
      default:    st_nxt = ST_DONE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lk;
    logic                    ls;
    logic signed [KEY_W-1:0] rk;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign ls = 1'b0;
    end else begin : g_mid
      assign lk = keys[i-1];
      assign ls = shifts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
    end else begin : g_next
      assign rk = keys[i+1];
    end
    slir_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .bc         (bc),
      .count      (cnt_r),
      .left_key   (lk),
      .left_shift (ls),
      .right_key  (rk),
      .key        (keys[i]),
      .shift      (shifts[i])
    );
  end

  // First level of the read tree: one gated OR per group of cells.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if ((g * GRP_SIZE + j) < CAPACITY) begin
          if (rd_ok && (CMP_W'(in_pos) == CMP_W'(g * GRP_SIZE + j))) begin
            grp_nxt[g] = grp_nxt[g] | keys[g * GRP_SIZE + j];
          end
        end
      end
    end
  end

  always_comb begin
    rd_final = '0;
    for (int g = 0; g < GROUPS; g++) begin
      rd_final = rd_final | grp_r[g];
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r   <= st_nxt;
      cnt1_r <= cnt_nxt;
      grp_r  <= grp_nxt;
    end
    if (load) begin
      out_st_r  <= st_r;
      out_rd_r  <= rd_final;
      out_cnt_r <= OUT_CNT_W'(cnt1_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_rd_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_PUSH) && full) |=> (cnt_r == $past(cnt_r)))
    else $error("push to full list changed the count");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    bc.remove |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("remove did not shrink the list");

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_free) |=> pend_r)
    else $error("pending result lost while output stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

/* hdl/slir_cell.sv */
// One storage cell of the sorted chain: holds one key and shifts with its neighbors.
module slir_cell import slir_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IDX = 0
) (
  input  logic                                   clk,
  input  bcast_t                                 bc,
  input  logic [$clog2(CAPACITY+1)-1:0]          count,
  input  logic signed [KEY_W-1:0]                left_key,
  input  logic                                   left_shift,
  input  logic signed [KEY_W-1:0]                right_key,
  output logic signed [KEY_W-1:0]                key,
  output logic                                   shift
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic                    occupied;
  logic                    at_tail;
  logic                    at_or_after_pos;

  assign occupied        = CNT_W'(IDX) < count;
  assign at_tail         = CNT_W'(IDX) == count;
  assign at_or_after_pos = CMP_W'(IDX) >= CMP_W'(bc.pos);
  // Occupied cells holding a greater key move one place right on a push.
  assign shift           = occupied && (key_r > bc.key);

  always_comb begin
    key_nxt = key_r;
    if (bc.push) begin
      if (left_shift) begin
        key_nxt = left_key;
      end else if (shift || at_tail) begin
        key_nxt = bc.key;
      end
    end else if (bc.remove && at_or_after_pos) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule
